// ===== sv/sptcq_pkg.sv =====
package sptcq_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int ID_BITS     = 16;
   localparam int NUM_CLASSES = 3;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH  = NUM_CLASSES * QUEUE_DEPTH;
   localparam int ADDR_BITS  = $clog2(MEM_DEPTH);

   localparam logic ACTION_ARRIVE = 1'b0;
   localparam logic ACTION_SERVE  = 1'b1;

   localparam logic [1:0] CLASS_NONE = 2'd0;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_CLS = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   typedef struct packed {
      logic        action;
      logic [15:0] item_id;
      logic [1:0]  class_code;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        served_valid;
      logic [15:0] served_id;
      logic [1:0]  served_class;
      logic [7:0]  count_high;
      logic [7:0]  count_mid;
      logic [7:0]  count_low;
   } rsp_word_type;

endpackage

// ===== sv/strict_priority_three_class_queue_core.sv =====
// Three-class strict priority queue of identifiers.
// req channel: one word per request. An arrive word appends item_id to the
// queue of class_code (1 highest .. 3 lowest); a full queue drops it, class
// zero is ignored. A serve word removes the head of the highest-priority
// non-empty queue.
// rsp channel: exactly one word per request, in request order, with status,
// the served identifier and class on a serve, and the three occupancy counts
// as they stand after the request.
// The response word is registered when the request is accepted;
// the served identifier comes from the entry memory read issued at accept.
// Throughput: one request per cycle while no response stalls. Pointers and counts
// sit in flops; the single entry memory is read or written at most once per request.
// Reset clears pointers, counts and the response valid flag; the entry memory
// is not cleared and needs no clearing pass.
// A stalled response holds its word; req_ready stays low until the pending
// response is taken, and rises in the same cycle that rsp_ready is seen.
module strict_priority_three_class_queue_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sptcq_pkg::req_word_type    req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sptcq_pkg::rsp_word_type    rsp_word
);

   localparam int NQ = sptcq_pkg::NUM_CLASSES;

   logic [sptcq_pkg::PTR_BITS-1:0] head_ff [NQ];
   logic [sptcq_pkg::PTR_BITS-1:0] head_in [NQ];
   logic [sptcq_pkg::PTR_BITS-1:0] tail_ff [NQ];
   logic [sptcq_pkg::PTR_BITS-1:0] tail_in [NQ];
   logic [sptcq_pkg::CNT_BITS-1:0] count_ff [NQ];
   logic [sptcq_pkg::CNT_BITS-1:0] count_in [NQ];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     status_ff, status_in;
   logic                           served_ff, served_in;
   logic [1:0]                     served_cls_ff, served_cls_in;
   logic [sptcq_pkg::ID_BITS-1:0]  rd_data_ff;

   logic [sptcq_pkg::ID_BITS-1:0]  entry_mem [sptcq_pkg::MEM_DEPTH];
   logic                           mem_we, mem_re;
   logic [sptcq_pkg::ADDR_BITS-1:0] mem_addr;
   logic [sptcq_pkg::ID_BITS-1:0]  mem_wdata;

   logic                           accept;
   logic [1:0]                     arr_q;
   logic [1:0]                     pick_q;
   logic                           pick_found;
   logic [1:0]                     acc_q;
   logic [sptcq_pkg::PTR_BITS-1:0] acc_ptr;

   function automatic logic [sptcq_pkg::PTR_BITS-1:0] ring_next(
      input logic [sptcq_pkg::PTR_BITS-1:0] p);
      if (p == sptcq_pkg::PTR_BITS'(sptcq_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign arr_q     = req_word.class_code - 2'd1;

   // fixed priority pick
   always_comb begin
      pick_found = 1'b1;
      pick_q     = 2'd0;
      if (count_ff[0] != '0) begin
         pick_q = 2'd0;
      end else if (count_ff[1] != '0) begin
         pick_q = 2'd1;
      end else if (count_ff[2] != '0) begin
         pick_q = 2'd2;
      end else begin
         pick_found = 1'b0;
      end
   end

   always_comb begin
      acc_q   = (req_word.action == sptcq_pkg::ACTION_SERVE) ? pick_q : arr_q;
      acc_ptr = (req_word.action == sptcq_pkg::ACTION_SERVE) ? head_ff[pick_q]
                                                             : tail_ff[arr_q];
      mem_addr = sptcq_pkg::ADDR_BITS'(acc_q) *
                 sptcq_pkg::ADDR_BITS'(sptcq_pkg::QUEUE_DEPTH) +
                 sptcq_pkg::ADDR_BITS'(acc_ptr);
      mem_wdata = req_word.item_id[sptcq_pkg::ID_BITS-1:0];
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      status_in     = status_ff;
      served_in     = served_ff;
      served_cls_in = served_cls_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         served_in     = 1'b0;
         served_cls_in = sptcq_pkg::CLASS_NONE;
         if (req_word.action == sptcq_pkg::ACTION_ARRIVE) begin
            if (req_word.class_code == sptcq_pkg::CLASS_NONE) begin
               status_in = sptcq_pkg::STATUS_BAD_CLS;
            end else if (count_ff[arr_q] >=
                         sptcq_pkg::CNT_BITS'(sptcq_pkg::QUEUE_DEPTH)) begin
               status_in = sptcq_pkg::STATUS_FULL;
            end else begin
               status_in       = sptcq_pkg::STATUS_DONE;
               mem_we          = 1'b1;
               tail_in[arr_q]  = ring_next(tail_ff[arr_q]);
               count_in[arr_q] = count_ff[arr_q] + 1'b1;
            end
         end else begin
            if (!pick_found) begin
               status_in = sptcq_pkg::STATUS_EMPTY;
            end else begin
               status_in        = sptcq_pkg::STATUS_DONE;
               mem_re           = 1'b1;
               served_in        = 1'b1;
               served_cls_in    = pick_q + 2'd1;
               head_in[pick_q]  = ring_next(head_ff[pick_q]);
               count_in[pick_q] = count_ff[pick_q] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NQ; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      served_ff     <= served_in;
      served_cls_ff <= served_cls_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= entry_mem[mem_addr];
      end
   end

   always_comb begin
      rsp_word              = '0;
      rsp_word.status       = status_ff;
      rsp_word.served_valid = served_ff;
      rsp_word.served_id    = served_ff ? 16'(rd_data_ff) : 16'd0;
      rsp_word.served_class = served_cls_ff;
      rsp_word.count_high   = 8'(count_ff[0]);
      rsp_word.count_mid    = 8'(count_ff[1]);
      rsp_word.count_low    = 8'(count_ff[2]);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= sptcq_pkg::CNT_BITS'(sptcq_pkg::QUEUE_DEPTH) &&
      count_ff[1] <= sptcq_pkg::CNT_BITS'(sptcq_pkg::QUEUE_DEPTH) &&
      count_ff[2] <= sptcq_pkg::CNT_BITS'(sptcq_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_serve_hit: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.action == sptcq_pkg::ACTION_SERVE && count_ff[0] != '0
      |=> rsp_valid && rsp_word.served_valid && rsp_word.served_class == 2'd1)
      else $error("serve missed nonempty high class");

   a_served_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.served_valid |->
      rsp_word.status == sptcq_pkg::STATUS_DONE &&
      rsp_word.served_class != sptcq_pkg::CLASS_NONE)
      else $error("served word with bad status or class");

   a_idle_state: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff[0]) && $stable(count_ff[1]) &&
      $stable(count_ff[2]))
      else $error("counts moved without a request");
`endif

endmodule
